### design/rtmp_chunk_stream_packer_defines.svh
// ----------------------------------------------------------------------------
// RTMP chunk stream packer assertion macros
// Immediate-style wrappers around concurrent assertions; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef RTMP_CHUNK_STREAM_PACKER_DEFINES_SVH
`define RTMP_CHUNK_STREAM_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RCSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define RCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define RCSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// rcsp_pkg
// Types, codes and constants shared by the RTMP chunk stream packer.
// ----------------------------------------------------------------------------
package rcsp_pkg;

  localparam int ID_W        = 17;
  localparam int MAX_BYTES   = 18;
  localparam int BURST_W     = MAX_BYTES * 8;
  localparam int CNT_W       = 5;
  localparam int CHANNEL_SLOTS_DEF = 64;

  localparam logic [23:0] MAX_CHUNK_RESET  = 24'd128;
  localparam logic [31:0] EXT_LIMIT        = 32'h00FF_FFFF;
  localparam logic [16:0] BASIC_ONE_MAX    = 17'd63;
  localparam logic [16:0] BASIC_TWO_MAX    = 17'd319;
  localparam logic [16:0] ID_OFFSET        = 17'd64;
  localparam logic [7:0]  CONT_MARK        = 8'hC0;

  // opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // chunk formats
  localparam logic [1:0] FMT_FULL   = 2'd0;
  localparam logic [1:0] FMT_MEDIUM = 2'd1;
  localparam logic [1:0] FMT_SMALL  = 2'd2;
  localparam logic [1:0] FMT_MIN    = 2'd3;

  // register index
  localparam logic REG_MAX_CHUNK = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [16:0] chunk_stream_id;
    logic [1:0]  header_format;
    logic [7:0]  message_type;
    logic [23:0] message_length;
    logic [31:0] message_stream_id;
    logic [31:0] timestamp;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       message_end;
  } out_item_t;

  // bytes of one run, first byte in the low bits
  typedef struct packed {
    logic [BURST_W-1:0] data;
    logic [CNT_W-1:0]   cnt;
    logic               msg_end;
  } burst_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] tag;
    logic [7:0]  mtype;
    logic [23:0] msg_length;
    logic [31:0] ts;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // message header length per format
  function automatic logic [3:0] msg_hdr_len(input logic [1:0] fmt);
    logic [3:0] len;
    unique case (fmt)
      FMT_FULL:   len = 4'd11;
      FMT_MEDIUM: len = 4'd7;
      FMT_SMALL:  len = 4'd3;
      default:    len = 4'd0;
    endcase
    return len;
  endfunction

  // 24-bit value in big-endian emission order
  function automatic logic [31:0] be3(input logic [23:0] v);
    return {8'h00, v[7:0], v[15:8], v[23:16]};
  endfunction

  // 32-bit value in big-endian emission order
  function automatic logic [31:0] be4(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // append k bytes of v (upper bytes already zero) to a run
  function automatic burst_t put(input burst_t b, input logic [31:0] v,
                                 input logic [2:0] k);
    burst_t r;
    r      = b;
    r.data = b.data | (BURST_W'(v) << {b.cnt, 3'b000});
    r.cnt  = b.cnt + CNT_W'(k);
    return r;
  endfunction

endpackage

### design/rcsp_ram.sv
// ----------------------------------------------------------------------------
// rcsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/rcsp_encoder.sv
// ----------------------------------------------------------------------------
// rcsp_encoder
// Builds the byte run for one item and keeps the open-message state.
// ----------------------------------------------------------------------------
module rcsp_encoder #(
  parameter int CHANNEL_SLOTS = rcsp_pkg::CHANNEL_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rcsp_pkg::in_item_t               item,
  input  logic [$clog2(CHANNEL_SLOTS)-1:0] slot,
  input  rcsp_pkg::slot_entry_t            rd_entry,
  input  logic [23:0]                      max_chunk,
  input  logic                             fire,
  output rcsp_pkg::burst_t                 burst,
  output logic                             wr_en,
  output rcsp_pkg::slot_entry_t            wr_entry
);
  import rcsp_pkg::*;

  localparam int SLOT_W = $clog2(CHANNEL_SLOTS);

  // open-message state
  logic [23:0] blm_r, blm_nxt;
  logic [23:0] blc_r, blc_nxt;
  logic [23:0] bhb_r, bhb_nxt;
  logic [1:0]  bhc_r, bhc_nxt;
  logic        ext_r, ext_nxt;
  logic [31:0] delta_r, delta_nxt;

  // last slot write, forwarded to a read issued on the same edge
  logic              lw_valid_r;
  logic [SLOT_W-1:0] lw_slot_r;
  slot_entry_t       lw_entry_r;

  slot_entry_t entry;
  logic        hit;
  logic [1:0]  fmt_a, fmt_b;
  logic [31:0] delta;
  logic        ext;
  logic [15:0] idm;
  logic [7:0]  b0;
  logic [1:0]  bcnt;
  logic [23:0] bas_val;
  logic [3:0]  hdr_len;
  logic [23:0] ts_field;
  logic [23:0] cs_eff;
  logic [23:0] blm_chunk;
  logic [23:0] len_chunk;
  logic [23:0] chunk;

  assign entry  = (lw_valid_r && lw_slot_r == slot) ? lw_entry_r : rd_entry;
  assign cs_eff = (max_chunk == 24'd0) ? 24'd1 : max_chunk;

  // format demotion against the previous message on this channel
  assign hit   = item.header_format != FMT_FULL && entry.valid &&
                 entry.tag == item.chunk_stream_id;
  assign fmt_a = (hit && item.header_format == FMT_MEDIUM &&
                  item.message_type == entry.mtype &&
                  item.message_length == entry.msg_length) ? FMT_SMALL
                                                           : item.header_format;
  assign fmt_b = (hit && fmt_a == FMT_SMALL && item.timestamp == entry.ts) ? FMT_MIN
                                                                           : fmt_a;
  assign delta    = item.timestamp - (hit ? entry.ts : 32'd0);
  assign ext      = delta >= EXT_LIMIT;
  assign ts_field = ext ? EXT_LIMIT[23:0] : delta[23:0];
  assign hdr_len  = msg_hdr_len(fmt_b);

  // basic header
  assign idm = 16'(item.chunk_stream_id - ID_OFFSET);
  always_comb begin
    if (item.chunk_stream_id > BASIC_TWO_MAX) begin
      b0      = {fmt_b, 6'd1};
      bcnt    = 2'd3;
      bas_val = {idm, b0};
    end else if (item.chunk_stream_id > BASIC_ONE_MAX) begin
      b0      = {fmt_b, 6'd0};
      bcnt    = 2'd2;
      bas_val = {8'h00, idm[7:0], b0};
    end else begin
      b0      = {fmt_b, item.chunk_stream_id[5:0]};
      bcnt    = 2'd1;
      bas_val = {16'h0000, b0};
    end
  end

  assign blm_chunk = (blm_r < cs_eff) ? blm_r : cs_eff;
  assign len_chunk = (item.message_length < cs_eff) ? item.message_length : cs_eff;
  assign chunk     = (blc_r == 24'd0) ? blm_chunk : blc_r;

  // run assembly and next state
  always_comb begin
    burst     = '0;
    blm_nxt   = blm_r;
    blc_nxt   = blc_r;
    bhb_nxt   = bhb_r;
    bhc_nxt   = bhc_r;
    ext_nxt   = ext_r;
    delta_nxt = delta_r;
    if (item.opcode == OP_PAYLOAD) begin
      if (blm_r != 24'd0) begin
        if (blc_r == 24'd0) begin
          burst = put(burst, {8'h00, bhb_r}, {1'b0, bhc_r});
          if (ext_r) begin
            burst = put(burst, be4(delta_r), 3'd4);
          end
        end
        burst         = put(burst, {24'h0, item.payload_byte}, 3'd1);
        burst.msg_end = blm_r == 24'd1;
        blc_nxt       = chunk - 24'd1;
        blm_nxt       = blm_r - 24'd1;
      end
    end else begin
      burst = put(burst, {8'h00, bas_val}, {1'b0, bcnt});
      if (hdr_len >= 4'd3) begin
        burst = put(burst, be3(ts_field), 3'd3);
      end
      if (hdr_len >= 4'd7) begin
        burst = put(burst, be3(item.message_length), 3'd3);
        burst = put(burst, {24'h0, item.message_type}, 3'd1);
      end
      if (hdr_len == 4'd11) begin
        burst = put(burst, item.message_stream_id, 3'd4);
      end
      if (ext) begin
        burst = put(burst, be4(delta), 3'd4);
      end
      burst.msg_end = item.message_length == 24'd0;
      blm_nxt   = item.message_length;
      blc_nxt   = len_chunk;
      bhb_nxt   = {bas_val[23:8], bas_val[7:0] | CONT_MARK};
      bhc_nxt   = bcnt;
      ext_nxt   = ext;
      delta_nxt = delta;
    end
  end

  // slot table update
  assign wr_en    = fire && item.opcode == OP_START;
  assign wr_entry = '{valid: 1'b1, tag: item.chunk_stream_id,
                      mtype: item.message_type,
                      msg_length: item.message_length, ts: item.timestamp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blm_r      <= '0;
      blc_r      <= '0;
      bhb_r      <= '0;
      bhc_r      <= '0;
      ext_r      <= 1'b0;
      delta_r    <= '0;
      lw_valid_r <= 1'b0;
    end else if (fire) begin
      blm_r   <= blm_nxt;
      blc_r   <= blc_nxt;
      bhb_r   <= bhb_nxt;
      bhc_r   <= bhc_nxt;
      ext_r   <= ext_nxt;
      delta_r <= delta_nxt;
      if (wr_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_slot_r  <= slot;
      lw_entry_r <= wr_entry;
    end
  end

endmodule

### design/rcsp_serializer.sv
// ----------------------------------------------------------------------------
// rcsp_serializer
// Holds one byte run and shifts it out one byte per transfer.
// ----------------------------------------------------------------------------
module rcsp_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  rcsp_pkg::burst_t      burst,
  output logic                  load_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rcsp_pkg::out_item_t   out_data
);
  import rcsp_pkg::*;

  logic [BURST_W-1:0] buf_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               end_r;
  logic               take;

  assign take      = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign load_ok   = cnt_r == '0 || (cnt_r == CNT_W'(1) && out_ready);

  assign out_data.out_byte    = buf_r[7:0];
  assign out_data.last_of_run = cnt_r == CNT_W'(1);
  assign out_data.message_end = cnt_r == CNT_W'(1) && end_r;

  // byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // byte shifter
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= burst.data;
      end_r <= burst.msg_end;
    end else if (take) begin
      buf_r <= buf_r >> 8;
    end
  end

endmodule

### design/rtmp_chunk_stream_packer.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_stream_packer
// Packs header and payload items into an RTMP chunk byte stream.
//
//   channel  ports                     direction  content
//   in       in_valid/in_ready/in_data  input     in_item_t, start or payload
//   out      out_valid/out_ready/out_data output  out_item_t, one stream byte
//   config   psel..pready               APB       max chunk length at byte 0
//
// Three register stages: input register (slot reciprocal multiply), slot
// index and table read, then run assembly into the output shifter.
// A payload byte inside a chunk makes a one-byte run. The output shifter sends
// one byte per cycle while out_ready is high; a new run loads only as the last
// byte of the previous run is taken. After reset a clearing pass writes every
// slot with in_ready low. A stalled output back-pressures all stages.
// ----------------------------------------------------------------------------
`include "rtmp_chunk_stream_packer_defines.svh"

module rtmp_chunk_stream_packer #(
  parameter int CHANNEL_SLOTS = rcsp_pkg::CHANNEL_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcsp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcsp_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rcsp_pkg::*;

  localparam int SLOT_W   = $clog2(CHANNEL_SLOTS);
  localparam int RECIP_SH = ID_W + SLOT_W;
  localparam int RECIP_W  = ID_W + 2;
  localparam longint RECIP =
    ((64'd1 << RECIP_SH) + CHANNEL_SLOTS - 1) / CHANNEL_SLOTS;

  // configuration
  logic [23:0] max_chunk_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_CHUNK) ? {8'h00, max_chunk_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_r <= MAX_CHUNK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CHUNK) begin
      max_chunk_r <= pwdata[23:0];
    end
  end

  // slot clearing pass after reset
  logic [SLOT_W-1:0] clr_cnt_r;
  logic              clr_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
      if (clr_cnt_r == SLOT_W'(CHANNEL_SLOTS - 1)) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  // pipeline control
  logic              a_valid_r, b_valid_r;
  in_item_t          a_item_r, b_item_r;
  logic [ID_W-1:0]   a_q_r;
  logic [SLOT_W-1:0] b_slot_r;
  logic              a_move, b_fire, ser_load_ok, ser_load;
  burst_t            burst;

  assign b_fire   = b_valid_r && (burst.cnt == '0 || ser_load_ok);
  assign ser_load = b_fire && burst.cnt != '0;
  assign a_move   = a_valid_r && (!b_valid_r || b_fire);
  assign in_ready = clr_done_r && (!a_valid_r || a_move);

  // quotient of id by the slot count via reciprocal multiply
  logic [ID_W+RECIP_W-1:0] q_prod;
  logic [ID_W-1:0]         a_slot_full;
  logic [SLOT_W-1:0]       a_slot;

  assign q_prod      = in_data.chunk_stream_id * RECIP_W'(RECIP);
  assign a_slot_full = a_item_r.chunk_stream_id - ID_W'(a_q_r * ID_W'(CHANNEL_SLOTS));
  assign a_slot      = a_slot_full[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r <= in_data;
      a_q_r    <= ID_W'(q_prod >> RECIP_SH);
    end
    if (a_move) begin
      b_item_r <= a_item_r;
      b_slot_r <= a_slot;
    end
  end

  // slot table
  logic        enc_wr_en, ram_wr_en;
  slot_entry_t enc_wr_entry, ram_wr_entry, rd_entry;
  logic [SLOT_W-1:0] ram_wr_addr;

  assign ram_wr_en    = !clr_done_r || enc_wr_en;
  assign ram_wr_addr  = clr_done_r ? b_slot_r : clr_cnt_r;
  assign ram_wr_entry = clr_done_r ? enc_wr_entry : '0;

  rcsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNEL_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_entry),
    .rd_en   (a_move),
    .rd_addr (a_slot),
    .rd_data (rd_entry)
  );

  rcsp_encoder #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS)
  ) u_encoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (b_item_r),
    .slot       (b_slot_r),
    .rd_entry   (rd_entry),
    .max_chunk  (max_chunk_r),
    .fire       (b_fire),
    .burst      (burst),
    .wr_en      (enc_wr_en),
    .wr_entry   (enc_wr_entry)
  );

  rcsp_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ser_load),
    .burst     (burst),
    .load_ok   (ser_load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `RCSP_ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, in_valid && in_ready, clr_done_r, "item accepted during slot clear")
  `RCSP_ASSERT_SAME(a_no_item_in_clear, clk, rst_n, !clr_done_r, !a_valid_r && !b_valid_r, "item in pipeline during slot clear")
  `RCSP_ASSERT_NEXT(a_stage_advance, clk, rst_n, a_valid_r && !b_valid_r, b_valid_r, "stage A did not advance into empty stage B")
  `RCSP_ASSERT_SAME(a_load_when_free, clk, rst_n, ser_load, ser_load_ok, "run loaded over undelivered bytes")

endmodule
